/* rtl/wcc_pkg.sv */
// Package for the weighted cluster centroid block.
// Holds field widths, coordinate limits, layer codes and the controller/datapath structs.
// No dependencies.
package wcc_pkg;

  // Field widths of the cell and result channels.
  localparam int ET_W    = 20;
  localparam int ETA_W   = 14;
  localparam int PHI_W   = 13;
  localparam int LAYER_W = 5;
  localparam int THR_W   = 20;

  // Accumulator and product widths.
  localparam int WSUM_W   = 42;
  localparam int ESUM_W   = 28;
  localparam int PETA_W   = ET_W + ETA_W;
  localparam int PPHI_W   = ET_W + PHI_W;
  localparam int DEN_W    = ESUM_W - 1;

  // Divider quotient widths: 14 raw bits, clamped to a 13-bit magnitude.
  localparam int QUOT_W = 14;
  localparam int LIM_W  = 13;

  // Saturation limits of the centroid coordinates.
  localparam logic [LIM_W-1:0] ETA_LIMIT = LIM_W'(5120);
  localparam logic [LIM_W-1:0] PHI_LIMIT = LIM_W'(3217);

  // Sampling layers that take part in the centroid.
  localparam logic [LAYER_W-1:0] LAYER_A = LAYER_W'(2);
  localparam logic [LAYER_W-1:0] LAYER_B = LAYER_W'(6);

  // Default cap on the number of cells per cluster.
  localparam int MAX_CELLS_DEF = 256;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // cell transfer: register products and count the cell
    logic acc;        // add registered products into the sums
    logic chk;        // start of cluster close: latch threshold result
    logic div_start;  // launch the shared divider
    logic div_phi;    // divider operand select: 1 for phi, 0 for eta
    logic cap_eta;    // capture divider result as eta
    logic cap_phi;    // capture divider result as phi
    logic load_out;   // load output register and clear the cluster
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sum_ok;     // energy sum exceeds the threshold
    logic div_done;   // divider result is ready
  } status_t;

endpackage

/* rtl/wcc_div.sv */
// Shared sequential divider with saturation for the centroid coordinates.
// Restoring division, one quotient bit per cycle; depends on wcc_pkg.
module wcc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [wcc_pkg::WSUM_W-1:0]   num,
  input  logic        [wcc_pkg::DEN_W-1:0]    den,
  input  logic        [wcc_pkg::LIM_W-1:0]    limit,
  output logic                                done,
  output logic                                neg,
  output logic        [wcc_pkg::LIM_W-1:0]    quot
);
  import wcc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WSUM_W-1:0] rem;
  logic [WSUM_W-1:0] dsh;
  logic [QUOT_W-1:0] q;
  logic              sat;
  logic [LIM_W-1:0]  lim;
  logic [WSUM_W-1:0] mag;
  logic [WSUM_W-1:0] den_top;
  logic              fits;

  // Magnitude of the dividend and the largest divisor shift that the quotient allows.
  assign mag     = num[WSUM_W-1] ? (~num + WSUM_W'(1)) : num;
  assign den_top = {1'b0, den, QUOT_W'(0)};
  assign fits    = rem >= dsh;

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CNT_W'(1);
        end
      end
    end
  end

  // Operands, partial remainder and quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= mag;
      dsh <= {2'b0, den, (QUOT_W - 1)'(0)};
      q   <= '0;
      sat <= mag >= den_top;
      neg <= num[WSUM_W-1];
      lim <= limit;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      q   <= {q[QUOT_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  // Clamp to the coordinate limit.
  assign quot = (sat || (q > QUOT_W'(lim))) ? lim : q[LIM_W-1:0];

endmodule

/* rtl/wcc_dp.sv */
// Datapath of the weighted cluster centroid: products, sums, threshold, result registers.
// Instantiates wcc_div; depends on wcc_pkg.
module wcc_dp #(
  parameter int MAX_CELLS = wcc_pkg::MAX_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  wcc_pkg::cmd_t                      cmd,
  output wcc_pkg::status_t                   status,
  input  logic                               cfg_we,
  input  logic        [wcc_pkg::THR_W-1:0]   cfg_wdata,
  input  logic signed [wcc_pkg::ET_W-1:0]    cell_et,
  input  logic signed [wcc_pkg::ETA_W-1:0]   cell_eta,
  input  logic signed [wcc_pkg::PHI_W-1:0]   cell_phi,
  input  logic        [wcc_pkg::LAYER_W-1:0] cell_layer,
  output logic signed [wcc_pkg::ETA_W-1:0]   centroid_eta,
  output logic signed [wcc_pkg::PHI_W-1:0]   centroid_phi,
  output logic                               centroid_valid
);
  import wcc_pkg::*;

  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  logic [THR_W-1:0]         min_total_et;
  logic [CNT_W-1:0]         cell_count;
  logic signed [PETA_W-1:0] prod_eta;
  logic signed [PPHI_W-1:0] prod_phi;
  logic signed [ET_W-1:0]   et_q;
  logic                     acc_en;
  logic [WSUM_W-1:0]        eta_sum;
  logic [WSUM_W-1:0]        phi_sum;
  logic [ESUM_W-1:0]        energy_sum;
  logic                     res_valid;
  logic signed [ETA_W-1:0]  res_eta;
  logic signed [PHI_W-1:0]  res_phi;
  logic                     div_neg;
  logic [LIM_W-1:0]         div_quot;
  logic [ETA_W-1:0]         quot_ext;
  logic [ETA_W-1:0]         quot_signed;
  logic                     div_done;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_total_et <= '0;
    end else if (cfg_we) begin
      min_total_et <= cfg_wdata;
    end
  end

  // Cell count, saturating at the cluster cap, cleared when the cluster closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= '0;
    end else if (cmd.load_out) begin
      cell_count <= '0;
    end else if (cmd.accept && (cell_count < CNT_W'(MAX_CELLS))) begin
      cell_count <= cell_count + CNT_W'(1);
    end
  end

  // Products of the accepted cell, registered ahead of the adders.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prod_eta <= cell_et * cell_eta;
      prod_phi <= cell_et * cell_phi;
      et_q     <= cell_et;
      acc_en   <= (cell_count < CNT_W'(MAX_CELLS)) &&
                  ((cell_layer == LAYER_A) || (cell_layer == LAYER_B));
    end
  end

  // Accumulators, wrapping at their widths.
  always_ff @(posedge clk) begin
    if (rst) begin
      eta_sum    <= '0;
      phi_sum    <= '0;
      energy_sum <= '0;
    end else if (cmd.load_out) begin
      eta_sum    <= '0;
      phi_sum    <= '0;
      energy_sum <= '0;
    end else if (cmd.acc && acc_en) begin
      eta_sum    <= eta_sum + {{(WSUM_W-PETA_W){prod_eta[PETA_W-1]}}, prod_eta};
      phi_sum    <= phi_sum + {{(WSUM_W-PPHI_W){prod_phi[PPHI_W-1]}}, prod_phi};
      energy_sum <= energy_sum + {{(ESUM_W-ET_W){et_q[ET_W-1]}}, et_q};
    end
  end

  // Signed energy sum against the unsigned threshold.
  assign status.sum_ok = $signed(energy_sum) >
                         $signed({{(ESUM_W-THR_W){1'b0}}, min_total_et});
  assign status.div_done = div_done;

  // One divider serves both coordinates, eta first.
  wcc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_phi ? $signed(phi_sum) : $signed(eta_sum)),
    .den   (energy_sum[DEN_W-1:0]),
    .limit (cmd.div_phi ? PHI_LIMIT : ETA_LIMIT),
    .done  (div_done),
    .neg   (div_neg),
    .quot  (div_quot)
  );

  // Apply the dividend sign to the clamped magnitude.
  assign quot_ext    = {{(ETA_W-LIM_W){1'b0}}, div_quot};
  assign quot_signed = div_neg ? (ETA_W'(0) - quot_ext) : quot_ext;

  // Result of the cluster being closed; coordinates stay zero when invalid.
  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      res_valid <= status.sum_ok;
      res_eta   <= '0;
      res_phi   <= '0;
    end else begin
      if (cmd.cap_eta) begin
        res_eta <= $signed(quot_signed);
      end
      if (cmd.cap_phi) begin
        res_phi <= $signed(quot_signed[PHI_W-1:0]);
      end
    end
  end

  // Output register, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      centroid_eta   <= res_eta;
      centroid_phi   <= res_phi;
      centroid_valid <= res_valid;
    end
  end

endmodule

/* rtl/wcc_ctrl.sv */
// Controller of the weighted cluster centroid: cell handshake, cluster close sequence
// and output valid. Drives wcc_dp through cmd_t; depends on wcc_pkg.
module wcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              last_cell,
  output logic              out_valid,
  input  logic              out_ready,
  input  wcc_pkg::status_t  status,
  output wcc_pkg::cmd_t     cmd
);
  import wcc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIVE = 3'd3;
  localparam logic [2:0] S_DIVP = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_q;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = last_q ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (status.sum_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVE;
        end else begin
          state_next = S_PUT;
        end
      end
      S_DIVE: begin
        if (status.div_done) begin
          cmd.cap_eta   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_phi   = 1'b1;
          state_next    = S_DIVP;
        end
      end
      S_DIVP: begin
        cmd.div_phi = 1'b1;
        if (status.div_done) begin
          cmd.cap_phi = 1'b1;
          state_next  = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and the last mark of the accepted cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.accept) begin
        last_q <= last_cell;
      end
    end
  end

  // Output valid: set on load, cleared by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/weighted_cluster_centroid_top.sv */
// Top level of the weighted cluster centroid block.
// Instantiates wcc_ctrl and wcc_dp; depends on wcc_pkg.
//
// Cells enter on the in_valid/in_ready channel, one transfer per cell, with et, eta,
// phi, layer and a last mark. Cells in layers 2 and 6 add et*eta, et*phi and et into
// three accumulators; at most MAX_CELLS cells of a cluster are counted.
// For each cell, the transfer registers the two products and the accumulate state
// then adds them; no new cell is taken before that add.
// The cell marked last closes the cluster. If the energy sum exceeds min_total_et,
// one shared divider computes eta and then phi, with the quotients truncated toward
// zero and saturated; otherwise the result is flagged invalid with zero coordinates.
// The close runs through the check state, the eta and phi divides (skipped for an
// invalid result) and the output state. With a free output register, out_valid is set
// by the same load that clears the accumulators.
// The result sits in an output register: while the receiver stalls, the next cluster's
// cells are still taken, and only the close of that next cluster waits for the register.
// The user writes min_total_et via cfg_we/cfg_wdata only while idle (not enforced).
// Synchronous reset clears the sums, the cell count, the threshold and out_valid.
module weighted_cluster_centroid_top #(
  parameter int MAX_CELLS = wcc_pkg::MAX_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic        [wcc_pkg::THR_W-1:0]   cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [wcc_pkg::ET_W-1:0]    cell_et,
  input  logic signed [wcc_pkg::ETA_W-1:0]   cell_eta,
  input  logic signed [wcc_pkg::PHI_W-1:0]   cell_phi,
  input  logic        [wcc_pkg::LAYER_W-1:0] cell_layer,
  input  logic                               last_cell,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [wcc_pkg::ETA_W-1:0]   centroid_eta,
  output logic signed [wcc_pkg::PHI_W-1:0]   centroid_phi,
  output logic                               centroid_valid
);
  import wcc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer for cell transfers and the cluster close.
  wcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_cell (last_cell),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and result registers.
  wcc_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cell_et        (cell_et),
    .cell_eta       (cell_eta),
    .cell_phi       (cell_phi),
    .cell_layer     (cell_layer),
    .centroid_eta   (centroid_eta),
    .centroid_phi   (centroid_phi),
    .centroid_valid (centroid_valid)
  );

  // An invalid result carries zero coordinates.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !centroid_valid) |-> (centroid_eta == '0) && (centroid_phi == '0))
    else $error("invalid centroid with nonzero coordinates");

  // Eta stays within its saturation range.
  a_eta_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (centroid_eta <= $signed({1'b0, ETA_LIMIT})) &&
                  (centroid_eta >= -$signed({1'b0, ETA_LIMIT})))
    else $error("centroid eta outside its range");

  // Phi stays within its saturation range.
  a_phi_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (centroid_phi <= $signed(PHI_LIMIT)) &&
                  (centroid_phi >= -$signed(PHI_LIMIT)))
    else $error("centroid phi outside its range");

  // A last cell closes the cluster, so no cell is taken in the following cycle.
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_cell) |=> !in_ready)
    else $error("cell taken right after a last cell");

endmodule
